[rtl/gww_pkg.sv]
// Shared types, constants and helper functions for the greedy word wrap block.
// Used by every module under rtl except gww_ram; depends on nothing else.
package gww_pkg;

  // Field and register widths.
  localparam int unsigned CH_W       = 8;
  localparam int unsigned LW_W       = 6;
  localparam int unsigned RL_W       = 9;
  localparam int unsigned IDX_OUT_W  = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;

  // Default buffer depth and the ceiling applied to the row limit.
  localparam int unsigned MAX_WIDTH_DEF = 40;
  localparam int unsigned ROW_CAP       = 256;

  // Register reset values.
  localparam logic [LW_W-1:0] LW_RESET = LW_W'(40);
  localparam logic [RL_W-1:0] RL_RESET = RL_W'(256);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LIMIT  = 1'b1;

  // Character codes.
  localparam logic [CH_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CH_W-1:0] CH_FF     = 8'h0C;
  localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CH_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CH_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CH_W-1:0] CH_PERIOD = 8'h2E;
  localparam logic [CH_W-1:0] CH_EXCL   = 8'h21;
  localparam logic [CH_W-1:0] CH_QUEST  = 8'h3F;
  localparam logic [CH_W-1:0] CH_HYPHEN = 8'h2D;

  // Status reported with the closing result of a text.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_CFG  = 2'd1,
    STAT_TOO_MANY = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_LINE_RD,
    S_LINE_OUT,
    S_MOVE_RD,
    S_MOVE_WR,
    S_PUT_CH,
    S_LOAD_B,
    S_CLOSE
  } ctl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // latch the input character
    logic eval;       // classify the character and update the line state
    logic line_rd;    // read the buffer at the emission index
    logic line_out;   // load one line result into the output register
    logic seg_b;      // the line being emitted is the final line of the text
    logic mv_rd;      // read a carried character
    logic mv_wr;      // write a carried character to the line start
    logic put;        // append the held character after the carried tail
    logic load_b;     // prepare emission of the final line
    logic close_out;  // load a standalone closing result
    logic finish;     // end of the transaction's work
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bad;        // configuration is unusable
    logic disc;       // rows exhausted, characters are being dropped
    logic eot;        // held character ends the text
    logic closes;     // held character closes the current line
    logic carried;    // the closed line leaves a tail for the next line
    logic lim;        // the closed line used the last row
    logic tail_zero;  // nothing to move for the carried tail
    logic move_last;  // current move step is the last one
    logic line_last;  // current emission step is the last of the line
    logic out_free;   // output register can take a result this cycle
  } dp_stat_t;

  // Line-ending characters.
  function automatic logic is_line_end(input logic [CH_W-1:0] c);
    logic r;
    r = 1'b0;
    case (c) inside
      CH_LF, CH_CR, CH_FF: r = 1'b1;
      default:             r = 1'b0;
    endcase
    return r;
  endfunction

  // Characters after which a line may be cut.
  function automatic logic is_break(input logic [CH_W-1:0] c);
    logic r;
    r = 1'b0;
    case (c) inside
      CH_SPACE, CH_COMMA, CH_SEMI, CH_COLON,
      CH_PERIOD, CH_EXCL, CH_QUEST, CH_HYPHEN: r = 1'b1;
      default:                                 r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

[rtl/gww_ram.sv]
// Generic simple dual-port RAM: one write port and one registered read port.
// Standalone; no package needed.
module gww_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 40,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/gww_ctrl.sv]
// Controller of the word wrap block: sequences evaluation, line emission,
// tail moves and closing results. Depends on gww_pkg.
module gww_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  gww_pkg::dp_stat_t stat_i,
  output gww_pkg::ctl_cmd_t cmd_o
);
  import gww_pkg::*;

  ctl_state_e state_q, state_d;
  logic       seg_b_q, seg_b_d;

  // State and segment registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      seg_b_q <= 1'b0;
    end else begin
      state_q <= state_d;
      seg_b_q <= seg_b_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    seg_b_d = seg_b_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat_i.bad || stat_i.disc) begin
          state_d = stat_i.eot ? S_CLOSE : S_IDLE;
        end else if (stat_i.closes) begin
          state_d = S_LINE_RD;
          seg_b_d = 1'b0;
        end else if (stat_i.eot) begin
          state_d = S_LINE_RD;
          seg_b_d = 1'b1;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_LINE_RD: begin
        state_d = S_LINE_OUT;
      end
      S_LINE_OUT: begin
        if (stat_i.out_free) begin
          if (!stat_i.line_last) begin
            state_d = S_LINE_RD;
          end else if (seg_b_q) begin
            state_d = S_IDLE;
          end else if (stat_i.carried && !stat_i.lim) begin
            state_d = stat_i.tail_zero ? S_PUT_CH : S_MOVE_RD;
          end else if (stat_i.eot && !stat_i.lim) begin
            state_d = S_LOAD_B;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_MOVE_RD: begin
        state_d = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        state_d = stat_i.move_last ? S_PUT_CH : S_MOVE_RD;
      end
      S_PUT_CH: begin
        state_d = stat_i.eot ? S_LOAD_B : S_IDLE;
      end
      S_LOAD_B: begin
        state_d = S_LINE_RD;
        seg_b_d = 1'b1;
      end
      S_CLOSE: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o      = '0;
    cmd_o.seg_b = seg_b_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (stat_i.bad || stat_i.disc) begin
          cmd_o.finish = !stat_i.eot;
        end else if (!stat_i.closes && !stat_i.eot) begin
          cmd_o.finish = 1'b1;
        end
      end
      S_LINE_RD: begin
        cmd_o.line_rd = 1'b1;
      end
      S_LINE_OUT: begin
        cmd_o.line_out = stat_i.out_free;
        if (stat_i.out_free && stat_i.line_last) begin
          if (seg_b_q) begin
            cmd_o.finish = 1'b1;
          end else if (!(stat_i.carried && !stat_i.lim) && !(stat_i.eot && !stat_i.lim)) begin
            cmd_o.finish = 1'b1;
          end
        end
      end
      S_MOVE_RD: begin
        cmd_o.mv_rd = 1'b1;
      end
      S_MOVE_WR: begin
        cmd_o.mv_wr = 1'b1;
      end
      S_PUT_CH: begin
        cmd_o.put    = 1'b1;
        cmd_o.finish = !stat_i.eot;
      end
      S_LOAD_B: begin
        cmd_o.load_b = 1'b1;
      end
      S_CLOSE: begin
        cmd_o.close_out = stat_i.out_free;
        cmd_o.finish    = stat_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

[rtl/gww_dp.sv]
// Datapath of the word wrap block: configuration, line state, the line
// buffer RAM and the output register. Depends on gww_pkg and gww_ram.
module gww_dp #(
  parameter int unsigned MAX_WIDTH = gww_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gww_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gww_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [gww_pkg::CH_W-1:0]        ch_i,
  input  logic                            end_of_text_i,
  input  logic                            out_stall_i,
  input  gww_pkg::ctl_cmd_t               cmd_i,
  output gww_pkg::dp_stat_t               stat_o,
  output logic                            out_valid_o,
  output logic [gww_pkg::CH_W-1:0]        out_char_o,
  output logic                            char_valid_o,
  output logic [gww_pkg::IDX_OUT_W-1:0]   line_index_o,
  output logic                            line_end_o,
  output logic                            text_done_o,
  output logic [gww_pkg::STATUS_W-1:0]    status_o,
  output logic [gww_pkg::COUNT_W-1:0]     line_count_o,
  output logic                            last_of_run_o
);
  import gww_pkg::*;

  localparam int unsigned IdxW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Configuration and line state.
  logic [LW_W-1:0] lw_q, lw_d;
  logic [RL_W-1:0] rl_q, rl_d;
  logic [LW_W-1:0] column_q, column_d;
  logic [LW_W-1:0] brk_q, brk_d;
  logic [RL_W-1:0] rows_q, rows_d;
  logic            disc_q, disc_d;

  // Per-transaction working registers.
  logic [CH_W-1:0] ch_q, ch_d;
  logic            eot_q, eot_d;
  logic [LW_W-1:0] len_q, len_d;
  logic [LW_W-1:0] cnt_q, cnt_d;
  logic [LW_W-1:0] tail_q, tail_d;
  logic            carried_q, carried_d;
  logic            lim_q, lim_d;

  // Output register.
  logic            out_valid_q, out_valid_d;
  logic [CH_W-1:0] out_char_q, out_char_d;
  logic            char_valid_q, char_valid_d;
  logic [IDX_OUT_W-1:0] line_index_q, line_index_d;
  logic            line_end_q, line_end_d;
  logic            text_done_q, text_done_d;
  status_e         status_q, status_d;
  logic [COUNT_W-1:0] line_count_q, line_count_d;
  logic            last_q, last_d;

  // Evaluation terms.
  logic [LW_W-1:0] width_eff, last_col, brk_inc, col_inc, len_a, tail_calc;
  logic [RL_W-1:0] rl_eff, rows_inc;
  logic            bad, normal, ch_le, ch_brk, at_last, closes, carries, lim;
  logic            line_last, move_last, out_free, final_seg, is_done, len_zero;

  // Buffer RAM ports.
  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  logic [CH_W-1:0] ram_wdata, ram_rdata;
  logic [LW_W-1:0] move_src;

  // Effective limits and classification of the held character.
  always_comb begin
    width_eff = (int'(lw_q) > MAX_WIDTH) ? LW_W'(MAX_WIDTH) : lw_q;
    rl_eff    = (int'(rl_q) > ROW_CAP) ? RL_W'(ROW_CAP) : rl_q;
    bad       = (lw_q == '0) || (rl_q == '0);
    normal    = !bad && !disc_q;
    last_col  = width_eff - LW_W'(1);
    ch_le     = is_line_end(ch_q);
    ch_brk    = is_break(ch_q);
    at_last   = (column_q == last_col);
    closes    = ch_le || at_last;
    carries   = !ch_le && !ch_brk && at_last && (brk_q != '0);
    brk_inc   = brk_q + LW_W'(1);
    col_inc   = column_q + LW_W'(1);
    rows_inc  = rows_q + RL_W'(1);
    lim       = closes && (rows_inc >= rl_eff);
    tail_calc = (last_col > brk_inc) ? (last_col - brk_inc) : '0;
    if (ch_le) begin
      len_a = column_q;
    end else if (carries) begin
      len_a = brk_inc;
    end else begin
      len_a = col_inc;
    end
  end

  // Emission and move progress.
  always_comb begin
    len_zero  = (len_q == '0);
    line_last = len_zero || ((cnt_q + LW_W'(1)) == len_q);
    move_last = ((cnt_q + LW_W'(1)) == tail_q);
    out_free  = !out_valid_q || !out_stall_i;
    final_seg = cmd_i.seg_b || !(eot_q && !lim_q);
    is_done   = line_last && final_seg && eot_q;
    move_src  = brk_q + LW_W'(1) + cnt_q;
  end

  // Status to the controller.
  always_comb begin
    stat_o.bad       = bad;
    stat_o.disc      = disc_q;
    stat_o.eot       = eot_q;
    stat_o.closes    = closes;
    stat_o.carried   = carried_q;
    stat_o.lim       = lim_q;
    stat_o.tail_zero = (tail_q == '0);
    stat_o.move_last = move_last;
    stat_o.line_last = line_last;
    stat_o.out_free  = out_free;
  end

  // Buffer port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = column_q[IdxW-1:0];
    ram_wdata = ch_q;
    if (cmd_i.eval) begin
      ram_we    = normal && !ch_le && !carries;
    end else if (cmd_i.mv_wr) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_q[IdxW-1:0];
      ram_wdata = ram_rdata;
    end else if (cmd_i.put) begin
      ram_we    = 1'b1;
      ram_waddr = tail_q[IdxW-1:0];
    end
    ram_re    = cmd_i.line_rd || cmd_i.mv_rd;
    ram_raddr = cmd_i.mv_rd ? move_src[IdxW-1:0] : cnt_q[IdxW-1:0];
  end

  gww_ram #(
    .WIDTH (CH_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next values of the configuration, line state and working registers.
  always_comb begin
    lw_d      = lw_q;
    rl_d      = rl_q;
    column_d  = column_q;
    brk_d     = brk_q;
    rows_d    = rows_q;
    disc_d    = disc_q;
    ch_d      = ch_q;
    eot_d     = eot_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    tail_d    = tail_q;
    carried_d = carried_q;
    lim_d     = lim_q;

    if (cmd_i.accept) begin
      ch_d  = ch_i;
      eot_d = end_of_text_i;
    end

    if (cmd_i.eval && normal) begin
      if (ch_le) begin
        column_d = '0;
        brk_d    = '0;
      end else if (ch_brk) begin
        column_d = at_last ? '0 : col_inc;
        brk_d    = at_last ? '0 : column_q;
      end else if (at_last) begin
        if (!carries) begin
          column_d = '0;
        end
      end else begin
        column_d = col_inc;
      end
      if (lim) begin
        column_d = '0;
        brk_d    = '0;
        if (!eot_q) begin
          disc_d = 1'b1;
        end
      end
      len_d     = closes ? len_a : col_inc;
      cnt_d     = '0;
      tail_d    = tail_calc;
      carried_d = carries;
      lim_d     = lim;
    end

    if (cmd_i.line_out) begin
      if (line_last) begin
        cnt_d  = '0;
        rows_d = rows_inc;
      end else begin
        cnt_d = cnt_q + LW_W'(1);
      end
    end

    if (cmd_i.mv_wr) begin
      cnt_d = move_last ? '0 : (cnt_q + LW_W'(1));
    end

    // Tail is in place; the held character follows it.
    if (cmd_i.put) begin
      column_d = tail_q + LW_W'(1);
      brk_d    = '0;
    end

    if (cmd_i.load_b) begin
      len_d = column_q;
      cnt_d = '0;
    end

    // A text that ends starts the next one from a clean state.
    if (cmd_i.finish && eot_q) begin
      column_d = '0;
      brk_d    = '0;
      rows_d   = '0;
      disc_d   = 1'b0;
    end

    // Register writes abort any text in progress.
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LINE_WIDTH: lw_d = cfg_wdata_i[LW_W-1:0];
        REG_ROW_LIMIT:  rl_d = cfg_wdata_i[RL_W-1:0];
        default:        lw_d = lw_q;
      endcase
      column_d = '0;
      brk_d    = '0;
      rows_d   = '0;
      disc_d   = 1'b0;
    end
  end

  // Next value of the output register.
  always_comb begin
    out_valid_d  = out_valid_q && out_stall_i;
    out_char_d   = out_char_q;
    char_valid_d = char_valid_q;
    line_index_d = line_index_q;
    line_end_d   = line_end_q;
    text_done_d  = text_done_q;
    status_d     = status_q;
    line_count_d = line_count_q;
    last_d       = last_q;
    if (cmd_i.line_out) begin
      out_valid_d  = 1'b1;
      out_char_d   = len_zero ? '0 : ram_rdata;
      char_valid_d = !len_zero;
      line_index_d = rows_q[IDX_OUT_W-1:0];
      line_end_d   = line_last;
      last_d       = line_last && final_seg;
      text_done_d  = is_done;
      status_d     = (is_done && lim_q && carried_q) ? STAT_TOO_MANY : STAT_OK;
      line_count_d = is_done ? COUNT_W'(rows_inc) : '0;
    end else if (cmd_i.close_out) begin
      out_valid_d  = 1'b1;
      out_char_d   = '0;
      char_valid_d = 1'b0;
      line_index_d = '0;
      line_end_d   = 1'b0;
      last_d       = 1'b1;
      text_done_d  = 1'b1;
      status_d     = bad ? STAT_BAD_CFG : STAT_TOO_MANY;
      line_count_d = bad ? '0 : COUNT_W'(rows_q);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q        <= LW_RESET;
      rl_q        <= RL_RESET;
      column_q    <= '0;
      brk_q       <= '0;
      rows_q      <= '0;
      disc_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      lw_q        <= lw_d;
      rl_q        <= rl_d;
      column_q    <= column_d;
      brk_q       <= brk_d;
      rows_q      <= rows_d;
      disc_q      <= disc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ch_q         <= ch_d;
    eot_q        <= eot_d;
    len_q        <= len_d;
    cnt_q        <= cnt_d;
    tail_q       <= tail_d;
    carried_q    <= carried_d;
    lim_q        <= lim_d;
    out_char_q   <= out_char_d;
    char_valid_q <= char_valid_d;
    line_index_q <= line_index_d;
    line_end_q   <= line_end_d;
    text_done_q  <= text_done_d;
    status_q     <= status_d;
    line_count_q <= line_count_d;
    last_q       <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign char_valid_o  = char_valid_q;
  assign line_index_o  = line_index_q;
  assign line_end_o    = line_end_q;
  assign text_done_o   = text_done_q;
  assign status_o      = status_q;
  assign line_count_o  = line_count_q;
  assign last_of_run_o = last_q;

endmodule

[rtl/greedy_word_wrap.sv]
// Top level of the greedy word wrap block: controller plus datapath.
// Depends on gww_pkg, gww_ctrl, gww_dp and gww_ram.
//
// Channel  Dir  Handshake                  Payload
// -------  ---  -------------------------  ---------------------------------
// input    in   in_valid_i / in_stall_o    ch_i, end_of_text_i
// result   out  out_valid_o / out_stall_i  out_char_o .. last_of_run_o
// config   in   cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// A character that closes no line is accepted, then evaluated.
// Each emitted line character is a buffer read then an output load. Each carried
// character is read and rewritten at the line start; then the held one is added.
// These steps are serial because the line buffer RAM has a single read port.
// Reset clears the line state and loads line width 40 and row limit 256.
// A stalled output holds the emission loop; the input stalls until a transaction's
// results are all loaded into the output register.
module greedy_word_wrap #(
  parameter int unsigned MAX_WIDTH = gww_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gww_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gww_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [gww_pkg::CH_W-1:0]        ch_i,
  input  logic                            end_of_text_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [gww_pkg::CH_W-1:0]        out_char_o,
  output logic                            char_valid_o,
  output logic [gww_pkg::IDX_OUT_W-1:0]   line_index_o,
  output logic                            line_end_o,
  output logic                            text_done_o,
  output logic [gww_pkg::STATUS_W-1:0]    status_o,
  output logic [gww_pkg::COUNT_W-1:0]     line_count_o,
  output logic                            last_of_run_o
);
  import gww_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Sequencer.
  gww_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Line state, buffer and output register.
  gww_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .ch_i          (ch_i),
    .end_of_text_i (end_of_text_i),
    .out_stall_i   (out_stall_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_char_o    (out_char_o),
    .char_valid_o  (char_valid_o),
    .line_index_o  (line_index_o),
    .line_end_o    (line_end_o),
    .text_done_o   (text_done_o),
    .status_o      (status_o),
    .line_count_o  (line_count_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the greedy word wrap block (greedy_word_wrap).
// Depends on gww_pkg for field widths, register indexes, character codes and status.
// A scoreboard class predicts each result from the accepted characters and checks it.
`timescale 1ns / 100ps

module tb_top;
  import gww_pkg::*;

  localparam int LINE_MAX     = MAX_WIDTH_DEF;
  localparam int IDLE_PCT     = 33;
  localparam int SETTLE_TICKS = 200;
  localparam int HOLD_TICKS   = 400;
  localparam int TICK_LIMIT   = 1000000;

  // One emitted result as the block presents it.
  typedef struct {
    logic [CH_W-1:0]      out_char;
    logic                 char_valid;
    logic [IDX_OUT_W-1:0] line_index;
    logic                 line_end;
    logic                 text_done;
    status_e              status;
    logic [COUNT_W-1:0]   line_count;
    logic                 last_of_run;
  } wrap_out_t;

  // Line state, configuration and the queue of results still owed by the block.
  class wrap_scoreboard;
    logic [CH_W-1:0] line_buf [LINE_MAX];
    int              col;
    int              brk_col;
    int              rows_done;
    bit              dropping;
    logic [LW_W-1:0] width_reg;
    logic [RL_W-1:0] rows_reg;
    wrap_out_t       due_q[$];
    wrap_out_t       burst[$];
    int              errors;

    function new();
      width_reg = LW_RESET;
      rows_reg  = RL_RESET;
      errors    = 0;
      restart();
    endfunction

    function void restart();
      col       = 0;
      brk_col   = 0;
      rows_done = 0;
      dropping  = 1'b0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // A register write also throws away any text in progress.
    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_LINE_WIDTH) begin
        width_reg = data[LW_W-1:0];
        restart();
      end else if (idx == REG_ROW_LIMIT) begin
        rows_reg = data[RL_W-1:0];
        restart();
      end
    endfunction

    function wrap_out_t mk_out(logic [CH_W-1:0] c, logic v, int row, logic le);
      wrap_out_t o;
      o.out_char    = c;
      o.char_valid  = v;
      o.line_index  = row[IDX_OUT_W-1:0];
      o.line_end    = le;
      o.text_done   = 1'b0;
      o.status      = STAT_OK;
      o.line_count  = '0;
      o.last_of_run = 1'b0;
      return o;
    endfunction

    // Queue one finished line; an empty line still gives one result.
    function void emit_line(int len);
      int n;
      int i;
      n = (len > LINE_MAX) ? LINE_MAX : len;
      if (n == 0) begin
        burst.push_back(mk_out(8'h00, 1'b0, rows_done, 1'b1));
      end else begin
        for (i = 0; i < n; i++)
          burst.push_back(mk_out(line_buf[i], 1'b1, rows_done, i + 1 == n));
      end
      rows_done++;
    endfunction

    // Work out the results of one accepted character transaction.
    function void take_char(logic [CH_W-1:0] c, bit eot);
      status_e   st;
      int        tally;
      int        w;
      int        rl;
      int        last_col;
      int        start;
      int        tail;
      int        i;
      bit        closed;
      bit        carried;
      wrap_out_t tip;
      st      = STAT_OK;
      tally   = 0;
      closed  = 1'b0;
      carried = 1'b0;
      burst.delete();
      if (width_reg == 0 || rows_reg == 0) begin
        if (!eot) return;
        burst.push_back(mk_out(8'h00, 1'b0, 0, 1'b0));
        st = STAT_BAD_CFG;
      end else if (dropping) begin
        if (!eot) return;
        burst.push_back(mk_out(8'h00, 1'b0, 0, 1'b0));
        st    = STAT_TOO_MANY;
        tally = rows_done;
      end else begin
        w        = (width_reg > LINE_MAX) ? LINE_MAX : int'(width_reg);
        rl       = (rows_reg > ROW_CAP) ? ROW_CAP : int'(rows_reg);
        last_col = w - 1;
        if (col > last_col) col = last_col;

        if (c inside {CH_LF, CH_CR, CH_FF}) begin
          emit_line(col);
          col     = 0;
          brk_col = 0;
          closed  = 1'b1;
        end else if (c inside {CH_SPACE, CH_COMMA, CH_SEMI, CH_COLON,
                               CH_PERIOD, CH_EXCL, CH_QUEST, CH_HYPHEN}) begin
          // A break in the last column closes the line on itself.
          brk_col       = col;
          line_buf[col] = c;
          if (col == last_col) begin
            emit_line(col + 1);
            col     = 0;
            brk_col = 0;
            closed  = 1'b1;
          end else begin
            col++;
          end
        end else if (col == last_col) begin
          // Overrun: cut at the overrun with no break, else just after the break.
          if (brk_col == 0) begin
            line_buf[col] = c;
            emit_line(col + 1);
            col = 0;
          end else begin
            emit_line(brk_col + 1);
            carried = 1'b1;
          end
          closed = 1'b1;
        end else begin
          line_buf[col] = c;
          col++;
        end

        if (closed && rows_done >= rl) begin
          // Rows are used up; any carried tail is lost.
          col     = 0;
          brk_col = 0;
          if (eot) begin
            st    = carried ? STAT_TOO_MANY : STAT_OK;
            tally = rows_done;
          end else begin
            dropping = 1'b1;
          end
        end else begin
          if (carried) begin
            start = brk_col + 1;
            tail  = (col > start) ? col - start : 0;
            for (i = 0; i < tail; i++) line_buf[i] = line_buf[start + i];
            col = tail;
            if (col < LINE_MAX) begin
              line_buf[col] = c;
              col++;
            end
            brk_col = 0;
          end
          if (eot) begin
            emit_line(col);
            st    = STAT_OK;
            tally = rows_done;
          end
        end
      end

      if (burst.size() == 0) return;
      i   = burst.size() - 1;
      tip = burst[i];
      if (eot) begin
        tip.text_done  = 1'b1;
        tip.status     = st;
        tip.line_count = tally[COUNT_W-1:0];
        restart();
      end
      tip.last_of_run = 1'b1;
      burst[i] = tip;
      foreach (burst[j]) due_q.push_back(burst[j]);
    endfunction

    function void field_check(string name, logic [15:0] want_v, logic [15:0] got_v);
      if (want_v !== got_v) begin
        $error("%s: expected %0d, got %0d", name, want_v, got_v);
        errors++;
      end
    endfunction

    // Compare one accepted result with the oldest owed one.
    function void check_out(wrap_out_t got);
      wrap_out_t want;
      if (due_q.size() == 0) begin
        $error("unexpected result: out_char %0d, line_index %0d", got.out_char,
               got.line_index);
        errors++;
        return;
      end
      want = due_q.pop_front();
      field_check("out_char", want.out_char, got.out_char);
      field_check("char_valid", want.char_valid, got.char_valid);
      field_check("line_index", want.line_index, got.line_index);
      field_check("line_end", want.line_end, got.line_end);
      field_check("text_done", want.text_done, got.text_done);
      field_check("status", want.status, got.status);
      field_check("line_count", want.line_count, got.line_count);
      field_check("last_of_run", want.last_of_run, got.last_of_run);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [CH_W-1:0]       ch_i;
  logic                  end_of_text_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [CH_W-1:0]       out_char_o;
  logic                  char_valid_o;
  logic [IDX_OUT_W-1:0]  line_index_o;
  logic                  line_end_o;
  logic                  text_done_o;
  logic [STATUS_W-1:0]   status_o;
  logic [COUNT_W-1:0]    line_count_o;
  logic                  last_of_run_o;

  wrap_scoreboard sb;
  int             chars_sent;
  int             ticks;
  logic           calm;
  logic           hold_out;

  greedy_word_wrap u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .ch_i          (ch_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .char_valid_o  (char_valid_o),
    .line_index_o  (line_index_o),
    .line_end_o    (line_end_o),
    .text_done_o   (text_done_o),
    .status_o      (status_o),
    .line_count_o  (line_count_o),
    .last_of_run_o (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one character and hold it until the block takes the transaction.
  task automatic send_char(input logic [CH_W-1:0] c, input bit eot);
    if (!calm && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    in_valid_i    <= 1'b1;
    ch_i          <= c;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_char(c, eot);
    chars_sent++;
  endtask

  // Stop offering, collect every owed result, then let trailing work finish.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    sb.set_register(idx, val[CFG_DATA_W-1:0]);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly letters, with breaks at a per-text density, line ends and raw bytes.
  function automatic logic [CH_W-1:0] pick_char(int brk_pct);
    int              roll;
    logic [CH_W-1:0] c;
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      case ($urandom_range(0, 2))
        0:       c = CH_LF;
        1:       c = CH_CR;
        default: c = CH_FF;
      endcase
    end else if (roll < 4 + brk_pct) begin
      case ($urandom_range(0, 7))
        0:       c = CH_SPACE;
        1:       c = CH_COMMA;
        2:       c = CH_SEMI;
        3:       c = CH_COLON;
        4:       c = CH_PERIOD;
        5:       c = CH_EXCL;
        6:       c = CH_QUEST;
        default: c = CH_HYPHEN;
      endcase
    end else if (roll < 14 + brk_pct) begin
      c = CH_W'($urandom_range(0, 255));
    end else begin
      c = 8'h61 + CH_W'($urandom_range(0, 25));
    end
    return c;
  endfunction

  task automatic run_directed();
    // Four columns, three rows: cut after a break, cut with no break, then rows run out.
    write_reg(REG_LINE_WIDTH, 4);
    write_reg(REG_ROW_LIMIT, 3);
    send_char("a", 1'b0);
    send_char(CH_SPACE, 1'b0);
    send_char("b", 1'b0);
    send_char("c", 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_COMMA, 1'b0);
    send_char(CH_LF, 1'b0);
    send_char("x", 1'b0);
    send_char("y", 1'b1);
    // Empty line, a break in the last column, and the limit met on the last character.
    send_char(CH_CR, 1'b0);
    send_char("a", 1'b0);
    send_char("b", 1'b0);
    send_char("c", 1'b0);
    send_char(CH_EXCL, 1'b0);
    send_char(CH_FF, 1'b1);
    // Zero width is a bad configuration.
    quiesce();
    write_reg(REG_LINE_WIDTH, 0);
    send_char("q", 1'b0);
    send_char("z", 1'b1);
    // Width above range with zero rows.
    quiesce();
    write_reg(REG_LINE_WIDTH, 63);
    write_reg(REG_ROW_LIMIT, 0);
    send_char("p", 1'b1);
    // Row limit above range; the remaining break characters.
    quiesce();
    write_reg(REG_ROW_LIMIT, 511);
    send_char(CH_SEMI, 1'b0);
    send_char(CH_COLON, 1'b0);
    send_char(CH_QUEST, 1'b0);
    send_char(CH_HYPHEN, 1'b0);
    send_char(CH_PERIOD, 1'b0);
    send_char("e", 1'b1);
  endtask

  task automatic run_random();
    int widths [12];
    int rows [12];
    int p;
    int i;
    int goal;
    int sent;
    int len;
    int brk_pct;
    bit close;
    widths = '{1, 40, 63, 3, 12, 40, 2, 25, 0, 7, 40, 5};
    rows   = '{256, 511, 3, 1, 256, 2, 511, 8, 256, 256, 0, 40};
    for (p = 0; p < 12; p++) begin
      quiesce();
      calm <= (p == 5);
      if ($urandom_range(0, 1)) begin
        write_reg(REG_LINE_WIDTH, widths[p]);
        write_reg(REG_ROW_LIMIT, rows[p]);
      end else begin
        write_reg(REG_ROW_LIMIT, rows[p]);
        write_reg(REG_LINE_WIDTH, widths[p]);
      end
      goal = (widths[p] == 0 || rows[p] == 0) ? 8 : 45;
      sent = 0;
      while (sent < goal) begin
        len = $urandom_range(1, 60);
        if (len > goal - sent) len = goal - sent;
        brk_pct = $urandom_range(0, 40);
        close   = ($urandom_range(0, 9) != 0);
        for (i = 0; i < len; i++) send_char(pick_char(brk_pct), close && (i == len - 1));
        sent += len;
      end
    end
  endtask

  // Result side: check each accepted transaction, then choose the next stall.
  always @(posedge clk_i) begin : drain_results
    wrap_out_t got;
    if (out_valid_o && !out_stall_i) begin
      got.out_char    = out_char_o;
      got.char_valid  = char_valid_o;
      got.line_index  = line_index_o;
      got.line_end    = line_end_o;
      got.text_done   = text_done_o;
      got.status      = status_e'(status_o);
      got.line_count  = line_count_o;
      got.last_of_run = last_of_run_o;
      sb.check_out(got);
    end
    out_stall_i <= hold_out || (!calm && ($urandom_range(0, 99) < IDLE_PCT));
  end

  // One long stall of the result side while characters keep coming; it starts
  // early in the twelve-column phase so that many characters are still to come.
  initial begin
    wait (chars_sent >= 215);
    @(posedge clk_i);
    hold_out <= 1'b1;
    repeat (HOLD_TICKS) @(posedge clk_i);
    hold_out <= 1'b0;
  end

  // Run limit.
  initial begin
    ticks = 0;
    forever begin
      @(posedge clk_i);
      ticks++;
      if (ticks >= TICK_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_LINE_WIDTH;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    ch_i          = '0;
    end_of_text_i = 1'b0;
    out_stall_i   = 1'b0;
    calm          = 1'b0;
    hold_out      = 1'b0;
    chars_sent    = 0;
    sb            = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    quiesce();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
